@@ sv/sovl_pkg.sv @@
`timescale 1ns / 1ps
package sovl_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [PIX_W-1:0] KEY_LUMA   = 8'd0;
    localparam logic [PIX_W-1:0] KEY_CHROMA = 8'd128;

    localparam logic [DIM_W-1:0] BASE_WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0] BASE_HEIGHT_RST   = 13'd480;
    localparam logic [DIM_W-1:0] SPRITE_WIDTH_RST  = 13'd64;
    localparam logic [DIM_W-1:0] SPRITE_HEIGHT_RST = 13'd64;
    localparam logic             KEY_ENABLE_RST    = 1'b0;
    localparam logic             AUTO_MOVE_RST     = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE_WIDTH    = 3'd0,
        REG_BASE_HEIGHT   = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_START_COL     = 3'd4,
        REG_START_ROW     = 3'd5,
        REG_KEY_ENABLE    = 3'd6,
        REG_AUTO_MOVE     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] base_y;
        logic [PIX_W-1:0] base_u;
        logic [PIX_W-1:0] base_v;
        logic [PIX_W-1:0] sprite_y;
        logic [PIX_W-1:0] sprite_u;
        logic [PIX_W-1:0] sprite_v;
    } in_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_y;
        logic [PIX_W-1:0] out_u;
        logic [PIX_W-1:0] out_v;
        logic             sprite_consumed;
        logic             frame_last;
    } out_pixel_t;

    // clamped dimensions and mode bits
    typedef struct packed {
        logic [DIM_W-1:0] bw;
        logic [DIM_W-1:0] bh;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic             key_en;
        logic             auto_move;
    } cfg_t;

    typedef struct packed {
        logic             col_load;
        logic             row_load;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } pos_load_t;

    typedef struct packed {
        logic in_win;
        logic last;
    } raster_stat_t;

endpackage

@@ sv/sovl_cfg.sv @@
`timescale 1ns / 1ps
module sovl_cfg #(
    parameter int MAX_DIM = sovl_pkg::MAX_DIM_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sovl_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sovl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output sovl_pkg::cfg_t                     cfg,
    output sovl_pkg::pos_load_t                ld
);
    import sovl_pkg::*;

    logic [DIM_W-1:0] base_width_reg, base_width_next;
    logic [DIM_W-1:0] base_height_reg, base_height_next;
    logic [DIM_W-1:0] sprite_width_reg, sprite_width_next;
    logic [DIM_W-1:0] sprite_height_reg, sprite_height_next;
    logic             key_enable_reg, key_enable_next;
    logic             auto_move_reg, auto_move_next;
    reg_idx_t         idx;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [31:0] limit);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > limit) begin
            r = limit[DIM_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign idx = reg_idx_t'(cfg_index);

    always_comb begin
        base_width_next    = base_width_reg;
        base_height_next   = base_height_reg;
        sprite_width_next  = sprite_width_reg;
        sprite_height_next = sprite_height_reg;
        key_enable_next    = key_enable_reg;
        auto_move_next     = auto_move_reg;
        ld.col_load        = 1'b0;
        ld.row_load        = 1'b0;
        ld.col             = cfg_wdata[POS_W-1:0];
        ld.row             = cfg_wdata[POS_W-1:0];
        if (cfg_we) begin
            unique case (idx)
                REG_BASE_WIDTH:    base_width_next    = cfg_wdata[DIM_W-1:0];
                REG_BASE_HEIGHT:   base_height_next   = cfg_wdata[DIM_W-1:0];
                REG_SPRITE_WIDTH:  sprite_width_next  = cfg_wdata[DIM_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_next = cfg_wdata[DIM_W-1:0];
                REG_START_COL:     ld.col_load        = 1'b1;
                REG_START_ROW:     ld.row_load        = 1'b1;
                REG_KEY_ENABLE:    key_enable_next    = cfg_wdata[0];
                REG_AUTO_MOVE:     auto_move_next     = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_width_reg    <= BASE_WIDTH_RST;
            base_height_reg   <= BASE_HEIGHT_RST;
            sprite_width_reg  <= SPRITE_WIDTH_RST;
            sprite_height_reg <= SPRITE_HEIGHT_RST;
            key_enable_reg    <= KEY_ENABLE_RST;
            auto_move_reg     <= AUTO_MOVE_RST;
        end else begin
            base_width_reg    <= base_width_next;
            base_height_reg   <= base_height_next;
            sprite_width_reg  <= sprite_width_next;
            sprite_height_reg <= sprite_height_next;
            key_enable_reg    <= key_enable_next;
            auto_move_reg     <= auto_move_next;
        end
    end

    always_comb begin
        cfg.bw        = clamp_dim(base_width_reg, 32'(MAX_DIM));
        cfg.bh        = clamp_dim(base_height_reg, 32'(MAX_DIM));
        cfg.sw        = clamp_dim(sprite_width_reg, 32'(cfg.bw));
        cfg.sh        = clamp_dim(sprite_height_reg, 32'(cfg.bh));
        cfg.key_en    = key_enable_reg;
        cfg.auto_move = auto_move_reg;
    end

endmodule

@@ sv/sovl_raster.sv @@
`timescale 1ns / 1ps
module sovl_raster #(
    parameter int MAX_DIM = sovl_pkg::MAX_DIM_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  sovl_pkg::cfg_t         cfg,
    input  sovl_pkg::pos_load_t    ld,
    output sovl_pkg::raster_stat_t stat
);
    import sovl_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int MW0   = (CNT_W > DIM_W) ? CNT_W : DIM_W;
    localparam int CW    = ((MW0 > POS_W) ? MW0 : POS_W) + 1;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             dir;
    } axis_t;

    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [POS_W-1:0] pos_col_reg, pos_col_next;
    logic [POS_W-1:0] pos_row_reg, pos_row_next;
    logic             dir_col_reg, dir_col_next;
    logic             dir_row_reg, dir_row_next;
    logic [CW-1:0]    col_e, row_e, pcol_e, prow_e;
    logic             col_end, row_end;
    axis_t            mv_col, mv_row;

    // one bounce step; decreasing when dir is set
    function automatic axis_t bounce(input logic [POS_W-1:0] pos, input logic dir,
                                     input logic [DIM_W-1:0] maxp);
        axis_t            r;
        logic [CW-1:0]    pos_w, max_w, inc;
        pos_w = CW'(pos);
        max_w = CW'(maxp);
        inc   = pos_w + CW'(1);
        r.pos = pos;
        r.dir = dir;
        if (!dir) begin
            if (pos_w < max_w) begin
                r.pos = inc[POS_W-1:0];
                if (inc == max_w) begin
                    r.dir = 1'b1;
                end
            end else begin
                r.dir = 1'b1;
            end
        end else begin
            if (pos != '0) begin
                r.pos = pos - POS_W'(1);
                if (pos == POS_W'(1)) begin
                    r.dir = 1'b0;
                end
            end else begin
                r.dir = 1'b0;
            end
        end
        return r;
    endfunction

    assign col_e  = CW'(col_count_reg);
    assign row_e  = CW'(row_count_reg);
    assign pcol_e = CW'(pos_col_reg);
    assign prow_e = CW'(pos_row_reg);

    assign col_end = col_e >= (CW'(cfg.bw) - CW'(1));
    assign row_end = row_e >= (CW'(cfg.bh) - CW'(1));

    assign stat.last   = col_end && row_end;
    assign stat.in_win = (col_e >= pcol_e) && ((col_e - pcol_e) < CW'(cfg.sw)) &&
                         (row_e >= prow_e) && ((row_e - prow_e) < CW'(cfg.sh));

    assign mv_col = bounce(pos_col_reg, dir_col_reg, cfg.bw - cfg.sw);
    assign mv_row = bounce(pos_row_reg, dir_row_reg, cfg.bh - cfg.sh);

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        pos_col_next   = pos_col_reg;
        pos_row_next   = pos_row_reg;
        dir_col_next   = dir_col_reg;
        dir_row_next   = dir_row_reg;
        if (step) begin
            if (col_end) begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row_count_reg + CNT_W'(1);
            end else begin
                col_count_next = col_count_reg + CNT_W'(1);
            end
            if (stat.last && cfg.auto_move) begin
                pos_col_next = mv_col.pos;
                dir_col_next = mv_col.dir;
                pos_row_next = mv_row.pos;
                dir_row_next = mv_row.dir;
            end
        end
        if (ld.col_load) begin
            pos_col_next = ld.col;
            dir_col_next = 1'b0;
        end
        if (ld.row_load) begin
            pos_row_next = ld.row;
            dir_row_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            pos_col_reg   <= '0;
            pos_row_reg   <= '0;
            dir_col_reg   <= 1'b0;
            dir_row_reg   <= 1'b0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            pos_col_reg   <= pos_col_next;
            pos_row_reg   <= pos_row_next;
            dir_col_reg   <= dir_col_next;
            dir_row_reg   <= dir_row_next;
        end
    end

endmodule

@@ sv/sovl_mix.sv @@
`timescale 1ns / 1ps
module sovl_mix (
    input  sovl_pkg::in_pixel_t    pix,
    input  sovl_pkg::raster_stat_t stat,
    input  logic                   key_en,
    output sovl_pkg::out_pixel_t   res
);
    import sovl_pkg::*;

    logic keyed;
    logic take;

    assign keyed = key_en && (pix.sprite_y == KEY_LUMA) &&
                   (pix.sprite_u == KEY_CHROMA) && (pix.sprite_v == KEY_CHROMA);
    assign take  = stat.in_win && !keyed;

    always_comb begin
        res.out_y           = take ? pix.sprite_y : pix.base_y;
        res.out_u           = take ? pix.sprite_u : pix.base_u;
        res.out_v           = take ? pix.sprite_v : pix.base_v;
        res.sprite_consumed = stat.in_win;
        res.frame_last      = stat.last;
    end

endmodule

@@ sv/sprite_overlay_color_key.sv @@
`timescale 1ns / 1ps
// A pixel accepted at the input is presented on m_data from the output register.
// Throughput: one pixel per cycle unless m_ready stalls; input register, compositing
// logic, output register: one pixel can wait at the input while a result stalls.
// Reset (aresetn low, synchronous): valids, raster counters, sprite position and
// direction cleared; registers return to their defaults.
module sprite_overlay_color_key #(
    parameter int MAX_DIM = sovl_pkg::MAX_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sovl_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [sovl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sovl_pkg::in_pixel_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sovl_pkg::out_pixel_t            m_data
);
    import sovl_pkg::*;

    cfg_t         cfg;
    pos_load_t    ld;
    raster_stat_t stat;
    out_pixel_t   res;

    in_pixel_t    in_data_reg, in_data_next;
    logic         in_vld_reg, in_vld_next;
    out_pixel_t   out_data_reg, out_data_next;
    logic         out_vld_reg, out_vld_next;
    logic         out_free;
    logic         advance;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign m_valid  = out_vld_reg;
    assign m_data   = out_data_reg;

    sovl_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .ld        (ld)
    );

    sovl_raster #(.MAX_DIM(MAX_DIM)) u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg),
        .ld      (ld),
        .stat    (stat)
    );

    sovl_mix u_mix (
        .pix    (in_data_reg),
        .stat   (stat),
        .key_en (cfg.key_en),
        .res    (res)
    );

    always_comb begin
        in_data_next  = in_data_reg;
        in_vld_next   = in_vld_reg;
        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg;
        if (s_valid && s_ready) begin
            in_data_next = s_data;
            in_vld_next  = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        if (advance) begin
            out_data_next = res;
            out_vld_next  = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // a pixel leaving the input register always lands in the output register
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("advanced pixel did not reach output register");

    // input stalls only with both stages full and the result side blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a full pipe");

    // a held pixel stays put in the input register
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_free) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("held input pixel lost or changed");

    // no result is issued from an empty input stage
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_vld_reg && out_free) |=> !out_vld_reg)
        else $error("result appeared without an input pixel");
`endif

endmodule

@@ test/tb_sprite_overlay_color_key.sv @@
`timescale 1ns / 1ps
module tb_sprite_overlay_color_key;
    import sovl_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 250;
    localparam int N_PHASES   = 16;
    localparam int PHASE_PX   = 125;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_pixel_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_pixel_t            m_data;

    sprite_overlay_color_key uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    in_pixel_t  pending_px[$];
    out_pixel_t composited_due[$];
    int unsigned pixels_offered = 0;
    int unsigned pixels_taken   = 0;
    int unsigned pixels_out     = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;
    logic        px_taken       = 1'b0;

    // shadow of the block's registers and raster/position state
    logic [DIM_W-1:0] cfg_bw   = BASE_WIDTH_RST;
    logic [DIM_W-1:0] cfg_bh   = BASE_HEIGHT_RST;
    logic [DIM_W-1:0] cfg_sw   = SPRITE_WIDTH_RST;
    logic [DIM_W-1:0] cfg_sh   = SPRITE_HEIGHT_RST;
    logic             cfg_key  = KEY_ENABLE_RST;
    logic             cfg_auto = AUTO_MOVE_RST;
    logic [POS_W-1:0] rast_col = '0;
    logic [POS_W-1:0] rast_row = '0;
    logic [POS_W-1:0] spr_col  = '0;
    logic [POS_W-1:0] spr_row  = '0;
    logic             spr_dir_col = 1'b0;
    logic             spr_dir_row = 1'b0;

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return 32'(v);
    endfunction

    // returns {dir, pos}; dir 1 = decreasing
    function automatic logic [POS_W:0] bounce_step(logic [POS_W-1:0] p, logic d,
                                                   int unsigned span);
        int unsigned pos;
        logic        dn;
        pos = 32'(p);
        dn  = d;
        if (!d) begin
            if (pos < span) begin
                pos = pos + 1;
                if (pos == span) dn = 1'b1;
            end else begin
                dn = 1'b1;
            end
        end else begin
            if (pos > 0) begin
                pos = pos - 1;
                if (pos == 0) dn = 1'b0;
            end else begin
                dn = 1'b0;
            end
        end
        return {dn, pos[POS_W-1:0]};
    endfunction

    task automatic composite_pixel(input in_pixel_t px, output out_pixel_t res);
        int unsigned      bw, bh, sw, sh, col, row;
        logic             inside_win, keyed, frame_end;
        logic [POS_W:0]   moved;
        bw  = eff_dim(cfg_bw, MAX_DIM_DEF);
        bh  = eff_dim(cfg_bh, MAX_DIM_DEF);
        sw  = eff_dim(cfg_sw, bw);
        sh  = eff_dim(cfg_sh, bh);
        col = 32'(rast_col);
        row = 32'(rast_row);
        inside_win = col >= spr_col && (col - spr_col) < sw &&
                     row >= spr_row && (row - spr_row) < sh;
        keyed = cfg_key && px.sprite_y == KEY_LUMA && px.sprite_u == KEY_CHROMA &&
                px.sprite_v == KEY_CHROMA;
        if (inside_win && !keyed) begin
            res.out_y = px.sprite_y;
            res.out_u = px.sprite_u;
            res.out_v = px.sprite_v;
        end else begin
            res.out_y = px.base_y;
            res.out_u = px.base_u;
            res.out_v = px.base_v;
        end
        res.sprite_consumed = inside_win;
        frame_end = 1'b0;
        if (col >= bw - 1) begin
            rast_col = '0;
            if (row >= bh - 1) begin
                rast_row  = '0;
                frame_end = 1'b1;
            end else begin
                rast_row = POS_W'(row + 1);
            end
        end else begin
            rast_col = POS_W'(col + 1);
        end
        res.frame_last = frame_end;
        if (frame_end && cfg_auto) begin
            moved       = bounce_step(spr_col, spr_dir_col, bw - sw);
            spr_col     = moved[POS_W-1:0];
            spr_dir_col = moved[POS_W];
            moved       = bounce_step(spr_row, spr_dir_row, bh - sh);
            spr_row     = moved[POS_W-1:0];
            spr_dir_row = moved[POS_W];
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_BASE_WIDTH:    cfg_bw = val;
            REG_BASE_HEIGHT:   cfg_bh = val;
            REG_SPRITE_WIDTH:  cfg_sw = val;
            REG_SPRITE_HEIGHT: cfg_sh = val;
            REG_START_COL: begin
                spr_col     = val[POS_W-1:0];
                spr_dir_col = 1'b0;
            end
            REG_START_ROW: begin
                spr_row     = val[POS_W-1:0];
                spr_dir_row = 1'b0;
            end
            REG_KEY_ENABLE:    cfg_key  = val[0];
            REG_AUTO_MOVE:     cfg_auto = val[0];
            default: ;
        endcase
    endtask

    task automatic offer_pixel(input in_pixel_t px);
        pending_px.push_back(px);
        pixels_offered++;
    endtask

    task automatic await_results();
        wait (pixels_out == pixels_offered);
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return 13'd0;
            1:       return 13'h1FFF;
            2:       return 13'd4096;
            3:       return 13'd1;
            4:       return 13'd4097;
            default: return DIM_W'($urandom_range(2, 12));
        endcase
    endfunction

    // sender: bursts with random gaps, valid held until the transfer
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !px_taken) begin
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (pending_px.size() != 0) begin
            s_data  <= pending_px.pop_front();
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 48);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // long receiver hold-off while the sender still has plenty queued
    int unsigned hold_cycles = 0;
    int unsigned holds_done  = 0;

    always @(negedge aclk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (holds_done < 2 && pixels_taken >= 500 + 700 * holds_done &&
                     pending_px.size() > 30) begin
            hold_cycles <= HOLD_LEN;
            holds_done  <= holds_done + 1;
        end
    end

    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;

    always @(negedge aclk) begin : rx_pattern
        logic rdy;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = $urandom_range(0, 3) != 0;
            default: rdy = $urandom_range(0, 7) == 0;
        endcase
        m_ready <= rdy && hold_cycles == 0;
        if (rx_tick == 99) begin
            rx_tick <= 0;
            rx_mode <= $urandom_range(0, 3);
        end else begin
            rx_tick <= rx_tick + 1;
        end
    end

    always @(posedge aclk) begin : scoreboard
        out_pixel_t want, got;
        if (!aresetn) begin
            px_taken    <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                pixels_out++;
                got = m_data;
                if (composited_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                end else begin
                    want = composited_due.pop_front();
                    if (got.out_y !== want.out_y || got.out_u !== want.out_u ||
                        got.out_v !== want.out_v ||
                        got.sprite_consumed !== want.sprite_consumed ||
                        got.frame_last !== want.frame_last) begin
                        mismatches++;
                        $display("%0t: mismatch, expected y=%0d u=%0d v=%0d cons=%b last=%b",
                                 $time, want.out_y, want.out_u, want.out_v,
                                 want.sprite_consumed, want.frame_last);
                        $display("%0t:          actual   y=%0d u=%0d v=%0d cons=%b last=%b",
                                 $time, got.out_y, got.out_u, got.out_v,
                                 got.sprite_consumed, got.frame_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                composite_pixel(s_data, want);
                composited_due.push_back(want);
                pixels_taken++;
            end
            px_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        in_pixel_t             px;
        logic [DIM_W-1:0]      bw, bh;
        logic [CFG_DATA_W-1:0] val;
        int unsigned           bw_eff, bh_eff, sel;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // 4x3 frame, 2x2 sprite at (1,1), keying and auto-move on
        write_reg(REG_BASE_WIDTH, 13'd4);
        write_reg(REG_BASE_HEIGHT, 13'd3);
        write_reg(REG_SPRITE_WIDTH, 13'd2);
        write_reg(REG_SPRITE_HEIGHT, 13'd2);
        write_reg(REG_START_COL, 13'd1);
        write_reg(REG_START_ROW, 13'd1);
        write_reg(REG_KEY_ENABLE, 13'd1);
        write_reg(REG_AUTO_MOVE, 13'd1);
        @(negedge aclk) cfg_we <= 1'b0;
        for (int i = 0; i < 24; i++) begin
            {px.base_y, px.base_u, px.base_v} = (i % 2) ? 24'hFFFFFF : 24'h000000;
            case (i % 3)
                0: {px.sprite_y, px.sprite_u, px.sprite_v} = {KEY_LUMA, KEY_CHROMA, KEY_CHROMA};
                1: case ((i / 3) % 3)
                       0:       {px.sprite_y, px.sprite_u, px.sprite_v} =
                                    {8'd1, KEY_CHROMA, KEY_CHROMA};
                       1:       {px.sprite_y, px.sprite_u, px.sprite_v} =
                                    {KEY_LUMA, 8'd127, KEY_CHROMA};
                       default: {px.sprite_y, px.sprite_u, px.sprite_v} =
                                    {KEY_LUMA, KEY_CHROMA, 8'd129};
                   endcase
                default: {px.sprite_y, px.sprite_u, px.sprite_v} =
                             (i % 2) ? 24'h000000 : 24'hFFFFFF;
            endcase
            offer_pixel(px);
        end
        await_results();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            bw = pick_dim();
            bh = pick_dim();
            bw_eff = (bw == 0) ? 1 : ((bw > MAX_DIM_DEF) ? MAX_DIM_DEF : bw);
            bh_eff = (bh == 0) ? 1 : ((bh > MAX_DIM_DEF) ? MAX_DIM_DEF : bh);
            write_reg(REG_BASE_WIDTH, bw);
            write_reg(REG_BASE_HEIGHT, bh);
            sel = $urandom_range(0, 7);
            val = CFG_DATA_W'((sel == 0) ? 13'd0 : (sel == 1) ? 13'h1FFF :
                              $urandom_range(1, bw_eff + 1));
            write_reg(REG_SPRITE_WIDTH, val);
            sel = $urandom_range(0, 7);
            val = CFG_DATA_W'((sel == 0) ? 13'd0 : (sel == 1) ? 13'h1FFF :
                              $urandom_range(1, bh_eff + 1));
            write_reg(REG_SPRITE_HEIGHT, val);
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                val = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 13'h1FFF :
                                  $urandom_range(0, bw_eff));
                write_reg(REG_START_COL, val);
                val = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 13'h1FFF :
                                  $urandom_range(0, bh_eff));
                write_reg(REG_START_ROW, val);
            end
            val = CFG_DATA_W'($urandom);
            write_reg(REG_KEY_ENABLE, val);
            val = CFG_DATA_W'(($urandom & 13'h1FFE) | ($urandom_range(0, 3) != 0));
            write_reg(REG_AUTO_MOVE, val);
            @(negedge aclk) cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_PX; n++) begin
                {px.base_y, px.base_u, px.base_v} = 24'($urandom);
                sel = $urandom_range(0, 7);
                if (sel < 2) begin
                    {px.sprite_y, px.sprite_u, px.sprite_v} = {KEY_LUMA, KEY_CHROMA, KEY_CHROMA};
                end else if (sel == 2) begin
                    {px.sprite_y, px.sprite_u, px.sprite_v} =
                        {KEY_LUMA, KEY_CHROMA, KEY_CHROMA} ^ (24'd1 << $urandom_range(0, 23));
                end else begin
                    {px.sprite_y, px.sprite_u, px.sprite_v} = 24'($urandom);
                end
                offer_pixel(px);
            end
            await_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && composited_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/sovl_pkg.sv
sv/sovl_cfg.sv
sv/sovl_raster.sv
sv/sovl_mix.sv
sv/sprite_overlay_color_key.sv
test/tb_sprite_overlay_color_key.sv
